>>> hw/rtl/aufs_pkg.sv
// Package for the Annex-B access unit flag scanner.
// Field widths, configuration register indexes and header class codes.
// No dependencies.
package aufs_pkg;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned PTS_W       = 63;
   localparam int unsigned CNT_W       = 25;
   localparam int unsigned REQ_TDATA_W = 72;   // data_byte + packet_pts, byte padded
   localparam int unsigned RSP_TDATA_W = 88;   // unit_bytes + unit_pts
   localparam int unsigned RSP_TUSER_W = 3;    // keyframe, config, dropped

   localparam logic [CNT_W-1:0] LIMIT_RESET = 25'h100_0000;   // 16 MiB

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_CODEC_SELECT  = 1'b0,
      CSR_AU_BYTE_LIMIT = 1'b1
   } csr_index_type;

   // codec selector values
   localparam logic CODEC_H264 = 1'b0;
   localparam logic CODEC_H265 = 1'b1;

   // header byte classes
   typedef enum logic [1:0] {
      CLS_NONE   = 2'd0,
      CLS_KEY    = 2'd1,
      CLS_CONFIG = 2'd2
   } hdr_class_type;

endpackage

>>> hw/rtl/aufs_hdr_classify.sv
// Header byte classifier for the access unit flag scanner.
// Maps a NAL header byte to keyframe / config / none per codec.
// Depends on aufs_pkg.
module aufs_hdr_classify (
   input  logic [aufs_pkg::DATA_W-1:0] hdr_byte,
   input  logic                        codec_select,
   output aufs_pkg::hdr_class_type     hdr_class
);

   logic [4:0] avc_type;
   logic [5:0] hevc_type;

   assign avc_type  = hdr_byte[4:0];
   assign hevc_type = hdr_byte[6:1];

   always_comb begin
      hdr_class = aufs_pkg::CLS_NONE;
      if (codec_select == aufs_pkg::CODEC_H264) begin
         unique case (avc_type) inside
            5'd5:       hdr_class = aufs_pkg::CLS_KEY;     // IDR slice
            5'd7, 5'd8: hdr_class = aufs_pkg::CLS_CONFIG;  // SPS, PPS
            default:    hdr_class = aufs_pkg::CLS_NONE;
         endcase
      end else begin
         unique case (hevc_type) inside
            [6'd16:6'd21]: hdr_class = aufs_pkg::CLS_KEY;     // IRAP range
            [6'd32:6'd34]: hdr_class = aufs_pkg::CLS_CONFIG;  // VPS, SPS, PPS
            default:       hdr_class = aufs_pkg::CLS_NONE;
         endcase
      end
   end

endmodule

>>> hw/rtl/annexb_access_unit_flag_scanner.sv
// Top level of the Annex-B access unit flag scanner.
// Input register, scan/accounting logic and result register.
// Depends on aufs_pkg and aufs_hdr_classify.

// The scanner takes one stream byte per transaction and hunts for Annex-B
// start codes (two or more zero bytes, then 0x01) inside each packet. The byte
// after a start code is the NAL header; it is classified as keyframe or
// parameter set under H.264 or H.265 rules (csr index 0). Flags are ORed over
// all packets of an access unit; the byte that carries tlast together with
// tuser (unit ends) produces one result transaction with the flags, the byte
// count (saturated at the limit of csr index 1), the timestamp of the first
// byte and a dropped flag. Throughput is one byte per cycle: a byte sits in the
// input register, the state update is a single pass of combinational logic (a
// 25 bit increment and compare sets the path), and the result lands in an
// output register; result valid follows the input and result registers. The
// input stage keeps accepting while a result waits; it only stalls when a
// unit-ending byte finds the result register still full. Configuration is
// written through csr_we/csr_index/csr_wdata, one register per cycle with no
// wait, and must only change while the block is idle.
module annexb_access_unit_flag_scanner (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write port
   input  logic                             csr_we,
   input  logic [0:0]                       csr_index,
   input  logic [aufs_pkg::CNT_W-1:0]       csr_wdata,
   // byte stream in
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [aufs_pkg::REQ_TDATA_W-1:0] req_tdata,   // [7:0] data_byte, [70:8] packet_pts
   input  logic                             req_tlast,   // packet_last
   input  logic                             req_tuser,   // unit_ends
   // access unit reports out
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [aufs_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [24:0] unit_bytes, [87:25] unit_pts
   output logic [aufs_pkg::RSP_TUSER_W-1:0] rsp_tuser    // [0] keyframe, [1] config, [2] dropped
);

   localparam int unsigned CNT_W = aufs_pkg::CNT_W;
   localparam int unsigned PTS_W = aufs_pkg::PTS_W;

   typedef struct packed {
      logic [PTS_W-1:0]           pts;
      logic                       ends;
      logic                       last;
      logic [aufs_pkg::DATA_W-1:0] data;
   } req_item_type;

   // configuration
   logic             codec_select_ff;
   logic [CNT_W-1:0] au_byte_limit_ff;

   // input stage
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         advance;
   logic         produces;

   // scan and unit state
   logic [1:0]              zero_cnt_ff, zero_cnt_in;
   logic                    expect_header_ff, expect_header_in;
   aufs_pkg::hdr_class_type pending_ff, pending_in;
   logic                    keyframe_ff, keyframe_in;
   logic                    config_ff, config_in;
   logic [CNT_W-1:0]        byte_count_ff, byte_count_in;
   logic [PTS_W-1:0]        first_pts_ff, first_pts_in;
   logic                    overflowed_ff, overflowed_in;

   // result register
   logic                             rsp_valid_ff;
   logic [aufs_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [aufs_pkg::RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   aufs_pkg::hdr_class_type hdr_class;

   aufs_hdr_classify u_classify (
      .hdr_byte     (in_item_ff.data),
      .codec_select (codec_select_ff),
      .hdr_class    (hdr_class)
   );

   // a unit-ending byte needs a free result register; other bytes never wait
   assign produces   = in_item_ff.last & in_item_ff.ends;
   assign advance    = in_valid_ff & (~produces | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~reset & (~in_valid_ff | advance);

   always_comb begin
      zero_cnt_in      = zero_cnt_ff;
      expect_header_in = expect_header_ff;
      pending_in       = pending_ff;
      keyframe_in      = keyframe_ff;
      config_in        = config_ff;
      byte_count_in    = byte_count_ff;
      first_pts_in     = first_pts_ff;
      overflowed_in    = overflowed_ff;

      // unit accounting, saturating at the limit
      if (byte_count_ff == '0 && !overflowed_ff) begin
         first_pts_in = in_item_ff.pts;
      end
      if (byte_count_ff < au_byte_limit_ff) begin
         byte_count_in = byte_count_ff + CNT_W'(1);
      end else begin
         overflowed_in = 1'b1;
         byte_count_in = au_byte_limit_ff;
      end

      // another byte in the packet commits a held H.265 hit
      if (pending_ff == aufs_pkg::CLS_KEY) begin
         keyframe_in = 1'b1;
      end else if (pending_ff == aufs_pkg::CLS_CONFIG) begin
         config_in = 1'b1;
      end
      pending_in = aufs_pkg::CLS_NONE;

      // start code scan
      if (expect_header_ff) begin
         if (codec_select_ff == aufs_pkg::CODEC_H264) begin
            if (hdr_class == aufs_pkg::CLS_KEY) begin
               keyframe_in = 1'b1;
            end else if (hdr_class == aufs_pkg::CLS_CONFIG) begin
               config_in = 1'b1;
            end
         end else begin
            pending_in = hdr_class;
         end
         expect_header_in = 1'b0;
         zero_cnt_in      = 2'd0;
      end else if (in_item_ff.data == 8'h00) begin
         if (zero_cnt_ff != 2'd2) begin
            zero_cnt_in = zero_cnt_ff + 2'd1;
         end
      end else if (in_item_ff.data == 8'h01 && zero_cnt_ff == 2'd2) begin
         expect_header_in = 1'b1;
         zero_cnt_in      = 2'd0;
      end else begin
         zero_cnt_in = 2'd0;
      end

      // report uses the flags after this byte's updates
      rsp_data_in = {first_pts_in, byte_count_in};
      rsp_user_in = {overflowed_in, config_in, keyframe_in};

      // headers never span packets
      if (in_item_ff.last) begin
         zero_cnt_in      = 2'd0;
         expect_header_in = 1'b0;
         pending_in       = aufs_pkg::CLS_NONE;
         if (in_item_ff.ends) begin
            keyframe_in   = 1'b0;
            config_in     = 1'b0;
            byte_count_in = '0;
            first_pts_in  = '0;
            overflowed_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_select_ff  <= aufs_pkg::CODEC_H264;
         au_byte_limit_ff <= aufs_pkg::LIMIT_RESET;
         in_valid_ff      <= 1'b0;
         zero_cnt_ff      <= 2'd0;
         expect_header_ff <= 1'b0;
         pending_ff       <= aufs_pkg::CLS_NONE;
         keyframe_ff      <= 1'b0;
         config_ff        <= 1'b0;
         byte_count_ff    <= '0;
         first_pts_ff     <= '0;
         overflowed_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               aufs_pkg::CSR_CODEC_SELECT:  codec_select_ff  <= csr_wdata[0];
               aufs_pkg::CSR_AU_BYTE_LIMIT: au_byte_limit_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         if (advance) begin
            zero_cnt_ff      <= zero_cnt_in;
            expect_header_ff <= expect_header_in;
            pending_ff       <= pending_in;
            keyframe_ff      <= keyframe_in;
            config_ff        <= config_in;
            byte_count_ff    <= byte_count_in;
            first_pts_ff     <= first_pts_in;
            overflowed_ff    <= overflowed_in;
         end

         if (advance && produces) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= '{pts:  req_tdata[70:8],
                         ends: req_tuser,
                         last: req_tlast,
                         data: req_tdata[7:0]};
      end
      if (advance && produces) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // zero run saturates at two
   a_zero_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      zero_cnt_ff != 2'd3)
      else $error("zero run counter went past two");

   // a start code always restarts the zero run
   a_hdr_clears_run: assert property (@(posedge clock) disable iff (reset)
      expect_header_ff |-> (zero_cnt_ff == 2'd0) && (pending_ff == aufs_pkg::CLS_NONE))
      else $error("header expected with zero run or pending class live");

   // a stalled byte stays in the input register
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled input byte lost");

   // a waiting result is never overwritten
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(advance && produces))
      else $error("result register overrun");

endmodule
